### rtl/core/linear_probe_hash_table_unit_macros.svh
// Assertion helpers for the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define LPHT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LPHT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/lpht_pkg.sv
package lpht_pkg;

    // Fixed field widths of the stream beats and the config register.
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 8;
    localparam int ENTRIES_W = 9;
    localparam int CFG_W     = 9;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISSING  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RESERVED = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_DONE
    } state_t;

    // Status of the bit-serial remainder unit.
    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

endpackage

### rtl/core/lpht_mod.sv
// Restoring remainder, one dividend bit per cycle.
module lpht_mod
    import lpht_pkg::*;
#(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 9
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,   // nonzero
    output mod_stat_t             stat,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]  div_reg, div_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    trial_sub;
    logic [DIVISOR_W-1:0]  rem_step;

    always_comb begin
        trial     = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        trial_sub = trial - {1'b0, div_reg};
        // trial < 2 * divisor, so the difference fits the divisor width
        if (trial >= {1'b0, div_reg}) begin
            rem_step = trial_sub[DIVISOR_W-1:0];
        end else begin
            rem_step = trial[DIVISOR_W-1:0];
        end
    end

    always_comb begin
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = dvd_reg << 1;
            rem_next = rem_step;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

### rtl/core/linear_probe_hash_table_unit.sv
// Open-addressed key/value table with linear probing, driven by stream beats.
// Each input beat carries op (lookup, insert/update, remove), key and value; each
// one gives exactly one result beat with status, found_value, slot and entries,
// unless a cfg write arrives before its result is loaded. After reset and after
// every cfg write the key memory is swept to the empty marker, all TABLE_DEPTH
// slots, during which s_tready stays low (cfg writes are still taken and restart
// the sweep). s_tready also drops while cfg_valid is high, so an input beat never
// shares an edge with a cfg write. An op code 3, a reserved all-ones key or an
// insert into a full table is answered without probing: the sequencer goes from
// idle straight to its done state, which loads the output register once it is
// free. Any other op finds its home slot in the bit-serial remainder unit, then
// probes one slot per cycle on the single registered read port of the key memory.
// One op is in flight at a time; its result sits in an output register, so the
// next beat can be taken while the result waits.
`include "linear_probe_hash_table_unit_macros.svh"

module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // cfg channel: slots_in_use
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata, low bit up: op[1:0], key[KEY_BITS], value[VALUE_BITS], zero pad
    input  logic [((OP_W+KEY_BITS+VALUE_BITS+7)/8)*8-1:0] s_tdata,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata, low bit up: status[1:0], found_value[VALUE_BITS], slot[7:0],
    // entries[8:0], zero pad
    output logic [((STATUS_W+VALUE_BITS+SLOT_W+ENTRIES_W+7)/8)*8-1:0] m_tdata
);

    localparam int RAW_W = STATUS_W + VALUE_BITS + SLOT_W + ENTRIES_W;
    localparam int OUT_W = ((RAW_W + 7) / 8) * 8;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CAP_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CAP_W > CFG_W) ? CAP_W : CFG_W;

    localparam logic [KEY_BITS-1:0] EMPTY_KEY = {KEY_BITS{1'b1}};
    localparam logic [IDX_W-1:0]    LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);

    // ---------------------------------------------------------------
    // Input beat fields
    // ---------------------------------------------------------------
    logic [OP_W-1:0]       in_op;
    logic [KEY_BITS-1:0]   in_key;
    logic [VALUE_BITS-1:0] in_val;

    assign in_op  = s_tdata[OP_W-1:0];
    assign in_key = s_tdata[OP_W +: KEY_BITS];
    assign in_val = s_tdata[OP_W+KEY_BITS +: VALUE_BITS];

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    state_t                state_reg, state_next;
    logic [CAP_W-1:0]      slots_reg, slots_next;      // capacity in use
    logic [CAP_W-1:0]      count_reg, count_next;      // occupied slots
    logic [IDX_W-1:0]      clr_idx_reg, clr_idx_next;  // clearing sweep pointer

    logic [OP_W-1:0]       op_reg, op_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;

    // Probe pipeline: address issued this cycle, data compared next cycle.
    logic [IDX_W-1:0]      addr_reg, addr_next;
    logic [CAP_W-1:0]      iss_cnt_reg, iss_cnt_next;
    logic [CAP_W-1:0]      cmp_cnt_reg, cmp_cnt_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]      rd_slot_reg, rd_slot_next;

    // Result held until the output register frees up.
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [VALUE_BITS-1:0] res_fval_reg, res_fval_next;
    logic [IDX_W-1:0]      res_slot_reg, res_slot_next;

    logic                  m_valid_reg, m_valid_next;
    logic [RAW_W-1:0]      m_data_reg, m_data_next;

    // ---------------------------------------------------------------
    // Key and value memories: one write port, one registered read port
    // ---------------------------------------------------------------
    logic [KEY_BITS-1:0]   key_mem [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0]   key_q_reg;
    logic [VALUE_BITS-1:0] val_q_reg;

    logic                  key_we;
    logic                  val_we;
    logic [IDX_W-1:0]      wr_addr;
    logic [KEY_BITS-1:0]   wr_key;

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[wr_addr] <= wr_key;
        end
        if (val_we) begin
            val_mem[wr_addr] <= val_reg;
        end
        key_q_reg <= key_mem[addr_reg];
        val_q_reg <= val_mem[addr_reg];
    end

    // ---------------------------------------------------------------
    // Home slot: key modulo capacity, bit-serial
    // ---------------------------------------------------------------
    logic             mod_start;
    mod_stat_t        mod_stat;
    logic [CAP_W-1:0] mod_rem;

    lpht_mod #(
        .DIVIDEND_W (KEY_BITS),
        .DIVISOR_W  (CAP_W)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (in_key),
        .divisor   (slots_reg),
        .stat      (mod_stat),
        .remainder (mod_rem)
    );

    // ---------------------------------------------------------------
    // Decode and probe compare
    // ---------------------------------------------------------------
    logic                cfg_fire;
    logic                in_fire;
    logic                quick;          // answered without probing
    logic [STATUS_W-1:0] quick_status;
    logic                probe_issue;
    logic                cmp_en;
    logic                hit;
    logic                last_cmp;
    logic                load_out;
    logic [CAP_W-1:0]    addr_p1;
    logic [IDX_W-1:0]    addr_step;
    logic [CMP_W-1:0]    cfg_ext;
    logic [CMP_W-1:0]    cfg_clamped;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = s_tvalid && s_tready;

    always_comb begin
        quick        = 1'b0;
        quick_status = STATUS_OK;
        if (in_op == OP_NONE) begin
            quick = 1'b1;
        end else if (in_key == EMPTY_KEY) begin
            quick        = 1'b1;
            quick_status = STATUS_RESERVED;
        end else if (in_op == OP_INSERT && count_reg >= slots_reg) begin
            // full even if the key is already present
            quick        = 1'b1;
            quick_status = STATUS_FULL;
        end
    end

    // insert stops on its key or on the first empty slot
    always_comb begin
        if (op_reg == OP_INSERT) begin
            hit = (key_q_reg == key_reg) || (key_q_reg == EMPTY_KEY);
        end else begin
            hit = (key_q_reg == key_reg);
        end
    end

    assign last_cmp  = (cmp_cnt_reg + 1'b1) == slots_reg;
    assign addr_p1   = CAP_W'(addr_reg) + 1'b1;
    assign addr_step = (addr_p1 >= slots_reg) ? '0 : addr_p1[IDX_W-1:0];

    always_comb begin
        cfg_ext = CMP_W'(cfg_data);
        if (cfg_ext == '0) begin
            cfg_clamped = CMP_W'(1);
        end else if (cfg_ext > CMP_W'(TABLE_DEPTH)) begin
            cfg_clamped = CMP_W'(TABLE_DEPTH);
        end else begin
            cfg_clamped = cfg_ext;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = quick ? ST_DONE : ST_HASH;
                end
            end
            ST_HASH: begin
                if (mod_stat.done) begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (cmp_en && (hit || last_cmp)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
        // new capacity empties the table
        if (cfg_fire) begin
            state_next = ST_CLEAR;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs
    // ---------------------------------------------------------------
    always_comb begin
        s_tready    = 1'b0;
        mod_start   = 1'b0;
        probe_issue = 1'b0;
        cmp_en      = 1'b0;
        load_out    = 1'b0;
        key_we      = 1'b0;
        val_we      = 1'b0;
        wr_addr     = rd_slot_reg;
        wr_key      = EMPTY_KEY;
        case (state_reg)
            ST_CLEAR: begin
                key_we  = 1'b1;
                wr_addr = clr_idx_reg;
            end
            ST_IDLE: begin
                // a pending cfg write wins over an input beat
                s_tready  = !cfg_valid;
                mod_start = s_tvalid && !cfg_valid && !quick;
            end
            ST_PROBE: begin
                probe_issue = iss_cnt_reg < slots_reg;
                cmp_en      = rd_valid_reg;
                if (rd_valid_reg && hit) begin
                    if (op_reg == OP_REMOVE) begin
                        key_we = 1'b1;
                    end else if (op_reg == OP_INSERT) begin
                        key_we = 1'b1;
                        val_we = 1'b1;
                        wr_key = key_reg;
                    end
                end
            end
            ST_DONE: begin
                load_out = !m_valid_reg || m_tready;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath next values
    // ---------------------------------------------------------------
    logic [CAP_W+ENTRIES_W-1:0] count_wide;
    logic [IDX_W+SLOT_W-1:0]    slot_wide;

    assign count_wide = {{ENTRIES_W{1'b0}}, count_reg};
    assign slot_wide  = {{SLOT_W{1'b0}}, res_slot_reg};

    always_comb begin
        slots_next      = slots_reg;
        count_next      = count_reg;
        clr_idx_next    = clr_idx_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        addr_next       = addr_reg;
        iss_cnt_next    = iss_cnt_reg;
        cmp_cnt_next    = cmp_cnt_reg;
        rd_valid_next   = 1'b0;
        rd_slot_next    = addr_reg;
        res_status_next = res_status_reg;
        res_fval_next   = res_fval_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        if (state_reg == ST_CLEAR) begin
            clr_idx_next = clr_idx_reg + 1'b1;
        end

        if (in_fire) begin
            op_next         = in_op;
            key_next        = in_key;
            val_next        = in_val;
            res_status_next = quick_status;
            res_fval_next   = '0;
            res_slot_next   = '0;
        end

        if (state_reg == ST_HASH) begin
            addr_next    = mod_rem[IDX_W-1:0];
            iss_cnt_next = '0;
            cmp_cnt_next = '0;
        end

        if (probe_issue) begin
            addr_next     = addr_step;
            iss_cnt_next  = iss_cnt_reg + 1'b1;
            rd_valid_next = !(cmp_en && (hit || last_cmp));
        end

        if (cmp_en) begin
            cmp_cnt_next = cmp_cnt_reg + 1'b1;
            if (hit) begin
                res_status_next = STATUS_OK;
                res_slot_next   = rd_slot_reg;
                if (op_reg == OP_LOOKUP) begin
                    res_fval_next = val_q_reg;
                end else if (op_reg == OP_REMOVE) begin
                    if (count_reg != '0) begin
                        count_next = count_reg - 1'b1;
                    end
                end else if (key_q_reg == EMPTY_KEY) begin
                    // insert into a fresh slot; an update keeps the count
                    count_next = count_reg + 1'b1;
                end
            end else if (last_cmp) begin
                // an insert that runs out of probes reports a full table
                res_status_next = (op_reg == OP_INSERT) ? STATUS_FULL : STATUS_MISSING;
            end
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
            m_data_next  = {count_wide[ENTRIES_W-1:0], slot_wide[SLOT_W-1:0],
                            res_fval_reg, res_status_reg};
        end

        if (cfg_fire) begin
            slots_next   = cfg_clamped[CAP_W-1:0];
            count_next   = '0;
            clr_idx_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        addr_reg       <= addr_next;
        iss_cnt_reg    <= iss_cnt_next;
        cmp_cnt_reg    <= cmp_cnt_next;
        rd_slot_reg    <= rd_slot_next;
        res_status_reg <= res_status_next;
        res_fval_reg   <= res_fval_next;
        res_slot_reg   <= res_slot_next;
        m_data_reg     <= m_data_next;
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            slots_reg    <= CAP_W'(TABLE_DEPTH);
            count_reg    <= '0;
            clr_idx_reg  <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            slots_reg    <= slots_next;
            count_reg    <= count_next;
            clr_idx_reg  <= clr_idx_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'(m_data_reg);

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `LPHT_ASSERT_IMPL(a_count_le_cap, aclk, aresetn, 1'b1, count_reg <= slots_reg, "entry count above capacity")
    `LPHT_ASSERT_IMPL(a_cap_range, aclk, aresetn, 1'b1, (slots_reg != '0) && (slots_reg <= CAP_W'(TABLE_DEPTH)), "capacity out of range")
    `LPHT_ASSERT_IMPL(a_idle_mod_quiet, aclk, aresetn, state_reg == ST_IDLE, !mod_stat.busy, "remainder unit busy while idle")
    `LPHT_ASSERT_IMPL(a_hash_mod_live, aclk, aresetn, state_reg == ST_HASH, mod_stat.busy || mod_stat.done, "hashing with remainder unit stopped")
    `LPHT_ASSERT_IMPL(a_result_from_done, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == ST_DONE, "result beat not loaded from done")

endmodule

### tb/sv/lpht_result_checker.sv
`timescale 1ns / 1ps

module lpht_result_checker
    import lpht_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int KEY_W = 32,
    parameter int VAL_W = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // op[1:0], key, value, zero pad
    input  logic [((OP_W+KEY_W+VAL_W+7)/8)*8-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // status[1:0], found_value, slot[7:0], entries[8:0], zero pad
    input  logic [((STATUS_W+VAL_W+SLOT_W+ENTRIES_W+7)/8)*8-1:0] m_tdata,
    output int                   results_pending,
    output int                   fail_count,
    output int                   results_checked,
    output logic [3:0]           status_seen
);

    localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

    // Packed low field last so a cast from m_tdata lines up.
    typedef struct packed {
        logic [ENTRIES_W-1:0] entries;
        logic [SLOT_W-1:0]    slot;
        logic [VAL_W-1:0]     found_value;
        logic [STATUS_W-1:0]  status;
    } table_result_t;

    logic [KEY_W-1:0] key_mem [DEPTH];
    logic [VAL_W-1:0] val_mem [DEPTH];
    int unsigned      fill;
    int unsigned      slots;

    table_result_t    expected_results [$];

    function automatic void empty_table();
        foreach (key_mem[i]) key_mem[i] = EMPTY_KEY;
        fill = 0;
    endfunction

    function automatic int unsigned next_slot(int unsigned s);
        return (s + 1 >= slots) ? 0 : s + 1;
    endfunction

    // Slot holding the key, or slots when it is absent.
    function automatic int unsigned locate_key(logic [KEY_W-1:0] key);
        int unsigned s;
        s = key % slots;
        for (int unsigned i = 0; i < slots; i++) begin
            if (key_mem[s] == key) return s;
            s = next_slot(s);
        end
        return slots;
    endfunction

    function automatic table_result_t apply_table_op(op_t op, logic [KEY_W-1:0] key,
                                                     logic [VAL_W-1:0] value);
        table_result_t r;
        int unsigned   s;
        logic          placed;
        r = '0;
        r.status = STATUS_OK;
        if (op != OP_NONE) begin
            if (key == EMPTY_KEY) begin
                r.status = STATUS_RESERVED;
            end else if (op == OP_LOOKUP || op == OP_REMOVE) begin
                s = locate_key(key);
                if (s == slots) begin
                    r.status = STATUS_MISSING;
                end else begin
                    r.slot = s[SLOT_W-1:0];
                    if (op == OP_LOOKUP) begin
                        r.found_value = val_mem[s];
                    end else begin
                        key_mem[s] = EMPTY_KEY;
                        if (fill != 0) fill--;
                    end
                end
            end else if (fill >= slots) begin
                r.status = STATUS_FULL;
            end else begin
                s = key % slots;
                placed = 1'b0;
                for (int unsigned i = 0; i < slots && !placed; i++) begin
                    if (key_mem[s] == EMPTY_KEY || key_mem[s] == key) placed = 1'b1;
                    else s = next_slot(s);
                end
                if (!placed) begin
                    r.status = STATUS_FULL;
                end else begin
                    if (key_mem[s] == EMPTY_KEY) fill++;
                    key_mem[s] = key;
                    val_mem[s] = value;
                    r.slot = s[SLOT_W-1:0];
                end
            end
        end
        r.entries = fill[ENTRIES_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        table_result_t want;
        table_result_t got;
        if (!aresetn) begin
            slots = DEPTH;
            empty_table();
            expected_results.delete();
            fail_count = 0;
            results_checked = 0;
            status_seen = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                slots = (cfg_data == 0) ? 1 : (cfg_data > DEPTH) ? DEPTH : cfg_data;
                empty_table();
            end
            // results first: a beat accepted now cannot be answered in the same cycle
            if (m_tvalid && m_tready) begin
                got = table_result_t'(m_tdata[$bits(table_result_t)-1:0]);
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing outstanding: 0x%0h", got);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("found_value", want.found_value, got.found_value);
                    check_field("slot", want.slot, got.slot);
                    check_field("entries", want.entries, got.entries);
                    status_seen[got.status] = 1'b1;
                    results_checked++;
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_table_op(op_t'(s_tdata[OP_W-1:0]),
                    s_tdata[OP_W +: KEY_W], s_tdata[OP_W+KEY_W +: VAL_W]));
        end
        results_pending = expected_results.size();
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lpht_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int S_W   = ((OP_W + KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int S_PAD = S_W - OP_W - KEY_BITS - VALUE_BITS;
    localparam int M_W   = ((STATUS_W + VALUE_BITS + SLOT_W + ENTRIES_W + 7) / 8) * 8;

    localparam logic [KEY_BITS-1:0] RESERVED_KEY = '1;

    // The limit allows several times the worst case of ~600 beats, each as slow as
    // the slowest beat, plus stalls and the post-reset / post-cfg sweeps.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_TICKS = 320;
    localparam int POOL_SIZE    = 24;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // op[1:0], key[33:2], value[65:34], zero pad
    logic [S_W-1:0]       s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // status[1:0], found_value[33:2], slot[41:34], entries[50:42], zero pad
    logic [M_W-1:0]       m_tdata;

    int         results_pending;
    int         mismatches;
    int         results_checked;
    logic [3:0] status_seen;

    bit idle_on     = 1'b1;   // cleared for one whole phase: back-to-back traffic
    int tick_count  = 0;
    int beats_sent  = 0;
    int sizes_tried = 0;

    linear_probe_hash_table_unit #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    lpht_result_checker #(
        .DEPTH (TABLE_DEPTH),
        .KEY_W (KEY_BITS),
        .VAL_W (VALUE_BITS)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .results_pending (results_pending),
        .fail_count      (mismatches),
        .results_checked (results_checked),
        .status_seen     (status_seen)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Result side: back-pressure ~12% of cycles while idling is on.
    always @(negedge aclk) begin
        m_tready <= !(idle_on && $urandom_range(99) < 12);
    end

    // Watchdog.
    always @(posedge aclk) begin
        tick_count <= tick_count + 1;
        if (tick_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // One input beat. Returns at the accepting rising edge; s_tvalid is only
    // touched again at the next falling edge, so a back-to-back beat keeps it high.
    task automatic send_beat(input op_t op, input logic [KEY_BITS-1:0] key,
                             input logic [VALUE_BITS-1:0] value);
        @(negedge aclk);
        while (idle_on && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{S_PAD{1'b0}}, value, key, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
    endtask

    // Hold the input side until every outstanding result has been taken.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (results_pending != 0) @(posedge aclk);
    endtask

    // Capacity writes only with the table idle; every op gives a result, so an
    // empty expectation queue means nothing is in flight. The write clears the table.
    task automatic write_capacity(input logic [CFG_W-1:0] code);
        wait_drained();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        sizes_tried++;
    endtask

    // Random traffic on one capacity. Keys come mostly from a small pool, about half of
    // it built to share home slots, so lookups hit, chains form and small tables fill.
    task automatic run_table_phase(input logic [CFG_W-1:0] code, input int n_beats);
        logic [KEY_BITS-1:0] pool [POOL_SIZE];
        logic [KEY_BITS-1:0] key;
        int unsigned         span;
        int                  pick;
        op_t                 op;
        span = (code == 0) ? 1 : (code > TABLE_DEPTH) ? TABLE_DEPTH : code;
        write_capacity(code);
        foreach (pool[j])
            pool[j] = $urandom_range(1) ? $urandom_range(5) * span + $urandom_range(3)
                                        : $urandom;
        for (int k = 0; k < n_beats; k++) begin
            if (k == n_beats / 2) wait_drained();   // mid-phase drain
            pick = $urandom_range(99);
            op = (pick < 44) ? OP_INSERT :
                 (pick < 70) ? OP_LOOKUP :
                 (pick < 94) ? OP_REMOVE : OP_NONE;
            pick = $urandom_range(99);
            key = (pick < 5)  ? RESERVED_KEY :
                  (pick < 15) ? $urandom : pool[$urandom_range(POOL_SIZE - 1)];
            send_beat(op, key, $urandom);
        end
    endtask

    initial begin
        logic [CFG_W-1:0] sizes [9];
        sizes = '{9'd1, 9'd2, 9'd3, 9'd7, 9'd16, 9'd64, 9'd255, 9'd256, 9'd40};

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed, reset capacity 256 ---
        send_beat(OP_LOOKUP, 32'd0, 32'd0);                   // missing key
        send_beat(OP_INSERT, 32'd0, 32'd0);                   // home slot 0
        send_beat(OP_INSERT, 32'hFFFF_FFFE, 32'hFFFF_FFFF);   // largest usable key
        send_beat(OP_LOOKUP, 32'hFFFF_FFFE, 32'd0);
        send_beat(OP_INSERT, 32'd256, 32'h5A5A_A5A5);         // collides, probes to slot 1
        send_beat(OP_LOOKUP, 32'd256, 32'd0);
        send_beat(OP_INSERT, 32'd256, 32'h1234_5678);         // update in place
        send_beat(OP_REMOVE, 32'd0, 32'hFFFF_FFFF);           // frees slot 0, no tombstone
        send_beat(OP_INSERT, 32'd256, 32'h0BAD_F00D);         // duplicate lands in slot 0
        send_beat(OP_LOOKUP, 32'd256, 32'd0);
        send_beat(OP_LOOKUP, RESERVED_KEY, 32'd0);            // reserved key, all ops
        send_beat(OP_INSERT, RESERVED_KEY, 32'hFFFF_FFFF);
        send_beat(OP_REMOVE, RESERVED_KEY, 32'd0);
        send_beat(OP_NONE, RESERVED_KEY, 32'hFFFF_FFFF);      // unused op code
        send_beat(OP_REMOVE, 32'd12345, 32'd0);               // remove of missing key

        // --- directed, capacity 0 taken as one slot ---
        write_capacity(9'd0);
        send_beat(OP_INSERT, 32'd5, 32'hCAFE_0001);
        send_beat(OP_INSERT, 32'd7, 32'hCAFE_0002);           // full
        send_beat(OP_INSERT, 32'd5, 32'hCAFE_0003);           // full even though present
        send_beat(OP_LOOKUP, 32'd5, 32'd0);
        send_beat(OP_REMOVE, 32'd5, 32'd0);
        send_beat(OP_INSERT, 32'd7, 32'h8000_0000);

        // --- directed, oversize capacity clamps to full depth, table cleared ---
        write_capacity(9'd511);
        send_beat(OP_LOOKUP, 32'd7, 32'd0);
        send_beat(OP_NONE, 32'h8000_0001, 32'd0);

        // --- random phases; one runs with no idling on either side ---
        foreach (sizes[p]) begin
            idle_on = (p != 4);
            run_table_phase(sizes[p], 58);
        end
        idle_on = 1'b1;
        run_table_phase(CFG_W'($urandom_range(4, 200)), 20);

        wait_drained();
        repeat (SETTLE_TICKS) @(posedge aclk);

        $display("Run: %0d input beats over %0d capacity settings, %0d results compared",
                 beats_sent, sizes_tried + 1, results_checked);
        $display("Status codes returned (one bit per code): %b", status_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/lpht_pkg.sv
rtl/core/lpht_mod.sv
rtl/core/linear_probe_hash_table_unit.sv
tb/sv/lpht_result_checker.sv
tb/sv/tb_top.sv
